// ----- rtl/hrp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, codes and constants of the HTTP request header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

   localparam int MAX_HEADER_DEF = 16384;
   localparam int MAX_WORD_DEF   = 4096;
   localparam int KEPT_CHARS_DEF = 15;
   localparam int QUEUE_DEPTH    = 4;

   localparam int HC_W       = 16;
   localparam int SPAN_LEN_W = 13;
   localparam int TOK_W      = 4;
   localparam int PAT_W      = 8 * 15;

   localparam logic [31:0] LEN_ABSENT = 32'hFFFF_FFFF;
   localparam logic [31:0] LEN_LIMIT  = 32'd214748364;

   localparam logic [TOK_W-1:0] TOK_METHOD   = 4'd1;
   localparam logic [TOK_W-1:0] TOK_URI      = 4'd2;
   localparam logic [TOK_W-1:0] TOK_VERSION  = 4'd3;
   localparam logic [TOK_W-1:0] TOK_LAST_REQ = 4'd7;
   localparam logic [TOK_W-1:0] TOK_HDR      = 4'd8;
   localparam logic [TOK_W-1:0] TOK_MAX      = 4'd9;

   localparam logic [PAT_W-1:0] PAT_GET     = "GET";
   localparam logic [PAT_W-1:0] PAT_HEAD    = "HEAD";
   localparam logic [PAT_W-1:0] PAT_POST    = "POST";
   localparam logic [PAT_W-1:0] PAT_OPTIONS = "OPTIONS";
   localparam logic [PAT_W-1:0] PAT_HTTP10  = "HTTP/1.0";
   localparam logic [PAT_W-1:0] PAT_HTTP11  = "HTTP/1.1";
   localparam logic [PAT_W-1:0] PAT_KEEP    = "keep-alive";
   localparam logic [PAT_W-1:0] PAT_HOST    = "host";
   localparam logic [PAT_W-1:0] PAT_CONN    = "connection";
   localparam logic [PAT_W-1:0] PAT_CLEN    = "content-length";

   typedef enum logic [3:0] {
      PH_WORD, PH_SPACE, PH_SPACE_EOL, PH_NAME, PH_NUMBER, PH_TO_EOL,
      PH_EOL, PH_WANT_LF, PH_LINE, PH_LAST_LF, PH_DONE
   } hrp_phase_type;

   typedef enum logic [1:0] {
      ST_PARSING, ST_DONE_OK, ST_DONE_ERR
   } hrp_status_type;

   typedef enum logic [2:0] {
      MT_NONE, MT_GET, MT_HEAD, MT_POST, MT_OPTIONS, MT_UNKNOWN
   } hrp_method_type;

   typedef enum logic [1:0] {
      VER_UNSET, VER_09, VER_10, VER_11
   } hrp_version_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       begin_req;
   } hrp_req_type;

   typedef struct packed {
      logic               consumed;
      logic [1:0]         status;
      logic [2:0]         method;
      logic [1:0]         version;
      logic               keep_alive;
      logic signed [31:0] content_length;
      logic [15:0]        uri_start;
      logic [12:0]        uri_length;
      logic [15:0]        host_start;
      logic [12:0]        host_length;
      logic [15:0]        header_length;
      logic [15:0]        request_line_length;
   } hrp_rsp_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       begin_req;
      logic       gt_space;
      logic       is_space;
      logic       is_tab;
      logic       is_cr;
      logic       is_lf;
      logic       is_colon;
      logic       is_digit;
      logic       is_high;
   } hrp_cls_type;

   function automatic logic [7:0] lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

endpackage

// ----- rtl/hrp_front.sv -----
// ----------------------------------------------------------------------------
// hrp_front
// Takes request bytes and classifies them before they enter the queue.
// ----------------------------------------------------------------------------
module hrp_front
   import hrp_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  hrp_req_type req_data,
   input  logic        q_full,
   output logic        q_push,
   output hrp_cls_type q_cls
);

   logic [7:0] b;

   assign b         = req_data.data_byte;
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cls.data_byte = b;
      q_cls.begin_req = req_data.begin_req;
      q_cls.gt_space  = (b > 8'h20);
      q_cls.is_space  = (b == 8'h20);
      q_cls.is_tab    = (b == 8'h09);
      q_cls.is_cr     = (b == 8'h0D);
      q_cls.is_lf     = (b == 8'h0A);
      q_cls.is_colon  = (b == 8'h3A);
      q_cls.is_digit  = (b >= 8'h30 && b <= 8'h39);
      q_cls.is_high   = b[7];
   end

endmodule

// ----- rtl/hrp_queue.sv -----
// ----------------------------------------------------------------------------
// hrp_queue
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module hrp_queue
   import hrp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  hrp_cls_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        q_valid,
   output hrp_cls_type q_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hrp_cls_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in;
   logic [PTR_W-1:0]       rd_ff, rd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_data  = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/hrp_back.sv -----
// ----------------------------------------------------------------------------
// hrp_back
// Parse engine, result register: one phase move per cycle unless stalled.
// ----------------------------------------------------------------------------
module hrp_back
   import hrp_pkg::*;
#(
   parameter int MAX_HEADER = MAX_HEADER_DEF,
   parameter int MAX_WORD   = MAX_WORD_DEF,
   parameter int KEPT_CHARS = KEPT_CHARS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  hrp_cls_type q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hrp_rsp_type rsp_data
);

   localparam int WC_W  = $clog2(MAX_WORD + 2);
   localparam int IDX_W = $clog2(KEPT_CHARS);

   hrp_phase_type                  ph_ff, ph_in, cur_ph;
   logic [WC_W-1:0]                wc_ff, wc_in, cur_wc;
   logic [TOK_W-1:0]               tok_ff, tok_in, cur_tok;
   logic [HC_W-1:0]                hc_ff, hc_in, cur_hc;
   logic                           err_ff, err_in, cur_err;
   logic                           host_ff, host_in, cur_host;
   logic                           conn_ff, conn_in, cur_conn;
   logic                           len_ff, len_in, cur_len;
   logic                           keep_ff, keep_in, cur_keep;
   hrp_method_type                 mc_ff, mc_in, cur_mc;
   hrp_version_type                vc_ff, vc_in, cur_vc;
   logic [31:0]                    lv_ff, lv_in, cur_lv;
   logic [HC_W-1:0]                us_ff, us_in, cur_us;
   logic [SPAN_LEN_W-1:0]          ul_ff, ul_in, cur_ul;
   logic [HC_W-1:0]                hs_ff, hs_in, cur_hs;
   logic [SPAN_LEN_W-1:0]          hl_ff, hl_in, cur_hl;
   logic [HC_W-1:0]                l1_ff, l1_in, cur_l1;
   logic                           first_ff;
   logic [KEPT_CHARS-1:0][7:0]     chars_ff;
   logic                           rsp_valid_ff;
   hrp_rsp_type                    rsp_ff;

   logic taken, chr_we, fatal_now, finish, out_free, step, hc_ok, clear;
   logic m_get, m_head, m_post, m_options, m_h10, m_h11, m_keep, m_host, m_conn, m_clen;
   hrp_rsp_type rsp_in;

   function automatic logic word_is(input logic [KEPT_CHARS-1:0][7:0] chars,
                                    input logic [WC_W-1:0] cnt,
                                    input logic [PAT_W-1:0] pat,
                                    input int n, input logic nocase);
      logic       ok;
      logic [7:0] a;
      logic [7:0] p;
      ok = (cnt == WC_W'(n)) && (n <= KEPT_CHARS);
      for (int i = 0; i < KEPT_CHARS; i++) begin
         if (i < n) begin
            a = chars[i];
            p = pat[8*(n-1-i) +: 8];
            if (nocase) begin
               a = lower(a);
               p = lower(p);
            end
            if (a != p) begin
               ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

   // begin clears the parse fields ahead of the first move on a byte
   assign clear = first_ff && q_data.begin_req;

   always_comb begin
      cur_ph   = clear ? PH_WORD     : ph_ff;
      cur_wc   = clear ? '0          : wc_ff;
      cur_tok  = clear ? '0          : tok_ff;
      cur_hc   = clear ? '0          : hc_ff;
      cur_err  = clear ? 1'b0        : err_ff;
      cur_host = clear ? 1'b0        : host_ff;
      cur_conn = clear ? 1'b0        : conn_ff;
      cur_len  = clear ? 1'b0        : len_ff;
      cur_keep = clear ? 1'b0        : keep_ff;
      cur_mc   = clear ? MT_NONE     : mc_ff;
      cur_vc   = clear ? VER_UNSET   : vc_ff;
      cur_lv   = clear ? LEN_ABSENT  : lv_ff;
      cur_us   = clear ? '0          : us_ff;
      cur_ul   = clear ? '0          : ul_ff;
      cur_hs   = clear ? '0          : hs_ff;
      cur_hl   = clear ? '0          : hl_ff;
      cur_l1   = clear ? '0          : l1_ff;
   end

   assign m_get     = word_is(chars_ff, cur_wc, PAT_GET, 3, 1'b0);
   assign m_head    = word_is(chars_ff, cur_wc, PAT_HEAD, 4, 1'b0);
   assign m_post    = word_is(chars_ff, cur_wc, PAT_POST, 4, 1'b0);
   assign m_options = word_is(chars_ff, cur_wc, PAT_OPTIONS, 7, 1'b0);
   assign m_h10     = word_is(chars_ff, cur_wc, PAT_HTTP10, 8, 1'b0);
   assign m_h11     = word_is(chars_ff, cur_wc, PAT_HTTP11, 8, 1'b0);
   assign m_keep    = word_is(chars_ff, cur_wc, PAT_KEEP, 10, 1'b1);
   assign m_host    = word_is(chars_ff, cur_wc, PAT_HOST, 4, 1'b1);
   assign m_conn    = word_is(chars_ff, cur_wc, PAT_CONN, 10, 1'b1);
   assign m_clen    = word_is(chars_ff, cur_wc, PAT_CLEN, 14, 1'b1);

   assign hc_ok = (cur_hc < HC_W'(MAX_HEADER));

   always_comb begin
      ph_in = cur_ph;   wc_in = cur_wc;     tok_in = cur_tok;   hc_in = cur_hc;
      err_in = cur_err; host_in = cur_host; conn_in = cur_conn; len_in = cur_len;
      keep_in = cur_keep; mc_in = cur_mc;   vc_in = cur_vc;     lv_in = cur_lv;
      us_in = cur_us;   ul_in = cur_ul;     hs_in = cur_hs;     hl_in = cur_hl;
      l1_in = cur_l1;
      taken = 1'b0;
      chr_we = 1'b0;
      fatal_now = 1'b0;
      case (cur_ph)
         PH_WORD: begin
            if (q_data.gt_space) begin
               taken  = 1'b1;
               chr_we = (cur_wc < WC_W'(KEPT_CHARS));
               wc_in  = cur_wc + 1'b1;
            end
            if (wc_in > WC_W'(MAX_WORD)) begin
               err_in = 1'b1;
               ph_in  = PH_DONE;
            end else if (!taken) begin
               ph_in  = PH_SPACE;
               tok_in = (cur_tok == TOK_MAX) ? cur_tok : cur_tok + 1'b1;
               hc_in  = cur_hc + HC_W'(cur_wc);
               if (tok_in == TOK_METHOD) begin
                  if (m_get) begin
                     mc_in = MT_GET;
                  end else if (m_head) begin
                     mc_in = MT_HEAD;
                  end else if (m_post) begin
                     mc_in = MT_POST;
                  end else if (m_options) begin
                     mc_in = MT_OPTIONS;
                  end else begin
                     mc_in  = MT_UNKNOWN;
                     err_in = 1'b1;
                     ph_in  = PH_TO_EOL;
                  end
               end else if (tok_in == TOK_URI) begin
                  us_in = cur_hc;
                  ul_in = SPAN_LEN_W'(cur_wc);
                  if (cur_wc == '0) begin
                     err_in = 1'b1;
                     ph_in  = PH_TO_EOL;
                  end
               end else if (tok_in == TOK_VERSION) begin
                  ph_in = PH_SPACE_EOL;
                  if (cur_wc == '0) begin
                     vc_in = VER_09;
                  end else if (m_h10) begin
                     vc_in = VER_10;
                  end else if (m_h11) begin
                     vc_in = VER_11;
                  end else begin
                     err_in = 1'b1;
                     ph_in  = PH_TO_EOL;
                  end
               end else begin
                  if (cur_wc != '0) begin
                     if (cur_host) begin
                        hs_in = cur_hc;
                        hl_in = SPAN_LEN_W'(cur_wc);
                     end else if (m_keep) begin
                        keep_in = 1'b1;
                     end
                  end
                  host_in = 1'b0;
                  conn_in = 1'b0;
                  ph_in   = PH_SPACE_EOL;
               end
            end
         end
         PH_SPACE, PH_SPACE_EOL: begin
            if (hc_ok && (q_data.is_space || (q_data.is_tab && cur_tok >= TOK_HDR))) begin
               hc_in = cur_hc + 1'b1;
               taken = 1'b1;
            end
            if (hc_in >= HC_W'(MAX_HEADER)) begin
               err_in = 1'b1;
               ph_in  = PH_DONE;
            end else if (!taken) begin
               if (cur_ph == PH_SPACE_EOL) begin
                  ph_in = PH_EOL;
               end else if (cur_tok < TOK_VERSION) begin
                  wc_in = '0;
                  ph_in = PH_WORD;
               end else if (cur_len) begin
                  if (cur_lv != LEN_ABSENT) begin
                     err_in = 1'b1;
                     ph_in  = PH_TO_EOL;
                  end else begin
                     lv_in = '0;
                     ph_in = PH_NUMBER;
                  end
               end else if (cur_host || cur_conn) begin
                  wc_in = '0;
                  ph_in = PH_WORD;
               end else begin
                  ph_in = PH_TO_EOL;
               end
            end
         end
         PH_NAME: begin
            if (!q_data.is_colon && q_data.gt_space && !q_data.is_high) begin
               taken  = 1'b1;
               chr_we = (cur_wc < WC_W'(KEPT_CHARS));
               wc_in  = cur_wc + 1'b1;
            end
            if (wc_in > WC_W'(MAX_WORD)) begin
               err_in = 1'b1;
               ph_in  = PH_DONE;
            end else if (!taken) begin
               if (!q_data.is_colon) begin
                  hc_in  = cur_hc + HC_W'(cur_wc);
                  err_in = 1'b1;
                  ph_in  = PH_TO_EOL;
               end else begin
                  taken = 1'b1;
                  if (m_host) begin
                     host_in = 1'b1;
                  end else if (m_conn) begin
                     conn_in = 1'b1;
                  end else if (m_clen) begin
                     len_in = 1'b1;
                  end else begin
                     host_in = 1'b0;
                     conn_in = 1'b0;
                     len_in  = 1'b0;
                  end
                  hc_in = cur_hc + HC_W'(cur_wc) + 1'b1;
                  ph_in = PH_SPACE;
               end
            end
         end
         PH_NUMBER: begin
            if (q_data.is_digit) begin
               if (cur_lv >= LEN_LIMIT) begin
                  err_in = 1'b1;
               end else begin
                  lv_in  = (cur_lv << 3) + (cur_lv << 1) + {28'd0, q_data.data_byte[3:0]};
                  hc_in  = cur_hc + 1'b1;
                  len_in = 1'b0;
                  taken  = 1'b1;
               end
            end
            if (!taken) begin
               if (cur_len) begin
                  err_in = 1'b1;
                  ph_in  = PH_TO_EOL;
               end else begin
                  ph_in = PH_SPACE_EOL;
               end
            end
         end
         PH_TO_EOL: begin
            if (hc_ok && !q_data.is_cr && !q_data.is_lf) begin
               hc_in = cur_hc + 1'b1;
               taken = 1'b1;
            end
            if (hc_in >= HC_W'(MAX_HEADER)) begin
               err_in = 1'b1;
               ph_in  = PH_DONE;
            end else if (!taken) begin
               ph_in = PH_EOL;
            end
         end
         PH_EOL: begin
            if (q_data.is_cr) begin
               hc_in = cur_hc + 1'b1;
               taken = 1'b1;
            end
            ph_in = PH_WANT_LF;
         end
         PH_WANT_LF: begin
            if (cur_tok < TOK_LAST_REQ) begin
               tok_in = TOK_HDR;
               if (cur_err) begin
                  ph_in     = PH_DONE;
                  fatal_now = 1'b1;
               end
            end else begin
               tok_in = (cur_tok < TOK_HDR) ? TOK_HDR : TOK_MAX;
            end
            if (!fatal_now) begin
               if (cur_vc == VER_UNSET || cur_vc == VER_09) begin
                  ph_in = PH_LAST_LF;
               end else if (!q_data.is_lf) begin
                  err_in = 1'b1;
                  ph_in  = PH_TO_EOL;
               end else begin
                  hc_in = cur_hc + 1'b1;
                  taken = 1'b1;
                  ph_in = PH_LINE;
               end
            end
         end
         PH_LINE: begin
            if (cur_l1 == '0) begin
               l1_in = cur_hc;
            end
            if (q_data.is_cr) begin
               hc_in = cur_hc + 1'b1;
               taken = 1'b1;
               ph_in = PH_LAST_LF;
            end else if (q_data.is_lf) begin
               ph_in = PH_LAST_LF;
            end else if (cur_err) begin
               ph_in = PH_TO_EOL;
            end else begin
               wc_in = '0;
               ph_in = PH_NAME;
            end
         end
         PH_LAST_LF: begin
            if (!q_data.is_lf) begin
               err_in = 1'b1;
               ph_in  = PH_DONE;
            end else begin
               hc_in = cur_hc + 1'b1;
               taken = 1'b1;
               if (cur_l1 == '0) begin
                  l1_in = hc_in;
               end
               ph_in = PH_DONE;
            end
         end
         default: begin
            ph_in = PH_DONE;
         end
      endcase
   end

   assign finish   = taken || (ph_in == PH_DONE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = q_valid && (!finish || out_free);
   assign q_pop    = step && finish;

   always_comb begin
      rsp_in.consumed            = taken;
      rsp_in.status              = (ph_in != PH_DONE) ? ST_PARSING :
                                   (err_in ? ST_DONE_ERR : ST_DONE_OK);
      rsp_in.method              = mc_in;
      rsp_in.version             = vc_in;
      rsp_in.keep_alive          = keep_in;
      rsp_in.content_length      = lv_in;
      rsp_in.uri_start           = us_in;
      rsp_in.uri_length          = ul_in;
      rsp_in.host_start          = hs_in;
      rsp_in.host_length         = hl_in;
      rsp_in.header_length       = hc_in;
      rsp_in.request_line_length = l1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_DONE;   wc_ff <= '0;      tok_ff <= '0;     hc_ff <= '0;
         err_ff <= 1'b0;     host_ff <= 1'b0;  conn_ff <= 1'b0;  len_ff <= 1'b0;
         keep_ff <= 1'b0;    mc_ff <= MT_NONE; vc_ff <= VER_UNSET;
         lv_ff <= LEN_ABSENT;
         us_ff <= '0;        ul_ff <= '0;      hs_ff <= '0;      hl_ff <= '0;
         l1_ff <= '0;
         first_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            ph_ff <= ph_in;     wc_ff <= wc_in;     tok_ff <= tok_in;   hc_ff <= hc_in;
            err_ff <= err_in;   host_ff <= host_in; conn_ff <= conn_in; len_ff <= len_in;
            keep_ff <= keep_in; mc_ff <= mc_in;     vc_ff <= vc_in;     lv_ff <= lv_in;
            us_ff <= us_in;     ul_ff <= ul_in;     hs_ff <= hs_in;     hl_ff <= hl_in;
            l1_ff <= l1_in;
            first_ff <= finish;
         end
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && chr_we) begin
         chars_ff[cur_wc[IDX_W-1:0]] <= q_data.data_byte;
      end
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/http_request_header_parser.sv -----
// path: a taken byte is written into the queue, parsed in hrp_back, and its result is
// held in the result register; throughput: 1 byte per cycle inside words and skipped
// text while results are taken; at word and line boundaries the parse engine in
// hrp_back moves through further phases before it takes the byte
// reset: synchronous, parser idle (done ok), queue and result register empty
// ----------------------------------------------------------------------------
// http_request_header_parser
// HTTP request header parser, one byte per transfer, one result per byte.
// ----------------------------------------------------------------------------
module http_request_header_parser
   import hrp_pkg::*;
#(
   parameter int MAX_HEADER = MAX_HEADER_DEF,
   parameter int MAX_WORD   = MAX_WORD_DEF,
   parameter int KEPT_CHARS = KEPT_CHARS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hrp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hrp_rsp_type rsp_data
);

   logic        q_full, q_push, q_pop, q_valid;
   hrp_cls_type q_cls, q_head;

   hrp_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cls     (q_cls)
   );

   hrp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_cls),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_head)
   );

   hrp_back #(
      .MAX_HEADER (MAX_HEADER),
      .MAX_WORD   (MAX_WORD),
      .KEPT_CHARS (KEPT_CHARS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_unconsumed_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.consumed || rsp_data.status != ST_PARSING))
      else $error("unconsumed byte while still parsing");

   a_line_within_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.request_line_length <= rsp_data.header_length))
      else $error("request line longer than header");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("queue not empty after reset");
`endif

endmodule
